// ----- src/tppa_pkg.sv -----
// ----------------------------------------------------------------------------
// tppa_pkg: shared types, constants and helpers
// Sizes, fixed-point helpers, the datapath command set and the step program
// of the principal angle engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tppa_pkg;

  // Element store sizes.
  localparam int MAX_DIM   = 1024;
  localparam int ELEM_BITS = 16;
  localparam int ADDR_W    = $clog2(MAX_DIM);
  localparam int CNT_W     = $clog2(MAX_DIM + 1);
  localparam int NVEC      = 4;

  // Stream payload widths; the input data width is padded to whole bytes.
  localparam int IN_W      = ((NVEC * ELEM_BITS + 7) / 8) * 8;
  localparam int OUT_W     = 64;
  localparam int USER_W    = 2;

  // Dot product lanes. Each product is exact; the sum of up to MAX_DIM of them
  // stays well inside ACC_W bits, so the accumulators never reach a limit.
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int ACC_W     = PROD_W + CNT_W;
  localparam int NDOT      = 10;

  // Vector and dot product indexes.
  localparam int V_A1 = 0;
  localparam int V_A2 = 1;
  localparam int V_B1 = 2;
  localparam int V_B2 = 3;

  localparam int D_A11 = 0;
  localparam int D_A22 = 1;
  localparam int D_A12 = 2;
  localparam int D_B11 = 3;
  localparam int D_B22 = 4;
  localparam int D_B12 = 5;
  localparam int D_X11 = 6;
  localparam int D_X12 = 7;
  localparam int D_X21 = 8;
  localparam int D_X22 = 9;

  localparam int DOT_L [NDOT] = '{V_A1, V_A2, V_A1, V_B1, V_B2, V_B1, V_A1, V_A1, V_A2, V_A2};
  localparam int DOT_R [NDOT] = '{V_A1, V_A2, V_A2, V_B1, V_B2, V_B2, V_B1, V_B2, V_B1, V_B2};

  // Scalar widths and limits.
  localparam int FIX_W     = 32;
  localparam int ROOT_W    = 32;
  localparam int RAD_W     = 64;
  localparam int DIV_N_W   = 48;
  localparam int DIV_D_W   = 32;
  localparam logic signed [FIX_W-1:0] FIX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [63:0] FIX_LIM64 = 64'sd2147483647;
  localparam logic signed [63:0] MAT_LIM64 = 64'sd4194303;

  // Datapath commands. The program steps come first so that the step counter
  // value is the command code itself.
  typedef enum logic [5:0] {
    CMD_ROUND,
    CMD_MUL_A12SQ, CMD_DD_A, CMD_MUL_DDA, CMD_SQ_A, CMD_SQRT_LA,
    CMD_MUL_B12SQ, CMD_DD_B, CMD_MUL_DDB, CMD_SQ_B, CMD_SQRT_LB,
    CMD_MUL_B12X11, CMD_NB, CMD_DIV_MB,
    CMD_MUL_A12X11, CMD_NC, CMD_DIV_MC,
    CMD_MUL_B12X21, CMD_R1, CMD_MUL_A12X12, CMD_R2, CMD_MUL_A12B12, CMD_R3,
    CMD_MUL_R3X11, CMD_R4, CMD_DIV_MD1, CMD_DIV_MD2,
    CMD_MA,
    CMD_MUL_MAMA, CMD_P1, CMD_MUL_MBMB, CMD_P2,
    CMD_MUL_MCMC, CMD_Q1, CMD_MUL_MDMD, CMD_Q2,
    CMD_MUL_MAMC, CMD_U1, CMD_MUL_MBMD, CMD_U2,
    CMD_RND,
    CMD_MUL_TT, CMD_TT, CMD_MUL_UU, CMD_UU,
    CMD_SQRT_S2, CMD_SQRT_BIG, CMD_SQRT_SMALL,
    CMD_NOP, CMD_DOT_INIT, CMD_DOT, CMD_OUT
  } cmd_e;

  localparam int PROG_LEN = int'(CMD_NOP);
  localparam int PC_W     = $bits(cmd_e);

  typedef struct packed {
    cmd_e step;
    logic start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic dot_done;
    logic unit_done;
    logic out_full;
  } status_t;

  // Steps that hand work to the divider or the square root unit.
  function automatic logic is_long(input cmd_e c);
    logic r;
    case (c)
      CMD_SQRT_LA, CMD_SQRT_LB, CMD_SQRT_S2, CMD_SQRT_BIG, CMD_SQRT_SMALL,
      CMD_DIV_MB, CMD_DIV_MC, CMD_DIV_MD1, CMD_DIV_MD2: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Saturate to the Q16.16 range.
  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [63:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > FIX_LIM64) begin
      r = FIX_MAX;
    end else if (v < -FIX_LIM64) begin
      r = -FIX_MAX;
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

  // Saturate to the matrix entry range (magnitude below 64).
  function automatic logic signed [FIX_W-1:0] sat_mat(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MAT_LIM64) begin
      r = MAT_LIM64;
    end else if (v < -MAT_LIM64) begin
      r = -MAT_LIM64;
    end else begin
      r = v;
    end
    return r[FIX_W-1:0];
  endfunction

  // Drop 16 fraction bits, rounding to nearest with ties upward.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = v + 64'sd32768;
    return w >>> 16;
  endfunction

endpackage

`default_nettype wire

// ----- src/tppa_sqrt.sv -----
// ----------------------------------------------------------------------------
// tppa_sqrt: iterative integer square root
// Floor square root of a 64-bit radicand, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tppa_pkg::RAD_W-1:0] rad_i,
  output logic                      done_o,
  output logic [tppa_pkg::ROOT_W-1:0] root_o
);
  import tppa_pkg::*;

  localparam int CNT_SQ_W = $clog2(ROOT_W);

  logic                  busy_q, done_q;
  logic [CNT_SQ_W-1:0]   cnt_q;
  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W+1:0]     rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [ROOT_W+3:0]     rem_sh, trial, diff;

  // One digit: bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_SQ_W'(ROOT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_SQ_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and root registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= diff[ROOT_W+1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[ROOT_W+1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- src/tppa_div.sv -----
// ----------------------------------------------------------------------------
// tppa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tppa_pkg::DIV_N_W-1:0] num_i,
  input  logic [tppa_pkg::DIV_D_W-1:0] den_i,
  output logic                         done_o,
  output logic [tppa_pkg::DIV_N_W-1:0] quo_o
);
  import tppa_pkg::*;

  localparam int CNT_DV_W = $clog2(DIV_N_W);

  logic                  busy_q, done_q;
  logic [CNT_DV_W-1:0]   cnt_q;
  logic [DIV_N_W-1:0]    quo_q;
  logic [DIV_D_W-1:0]    den_q;
  logic [DIV_D_W-1:0]    rem_q;
  logic [DIV_D_W:0]      rem_sh, diff;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_N_W-1]};
    diff   = rem_sh - {1'b0, den_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_DV_W'(DIV_N_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_DV_W'(DIV_N_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= diff[DIV_D_W-1:0];
        quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIV_D_W-1:0];
        quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- src/tppa_dp.sv -----
// ----------------------------------------------------------------------------
// tppa_dp: datapath of the principal angle engine
// Element stores, ten dot product lanes, a shared multiplier, the divider and
// square root units, the scalar registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tppa_pkg::cmd_t              cmd_i,
  output tppa_pkg::status_t           status_o,
  input  logic [tppa_pkg::IN_W-1:0]   in_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [tppa_pkg::OUT_W-1:0]  out_data_o,
  output logic [tppa_pkg::USER_W-1:0] out_user_o
);
  import tppa_pkg::*;

  // Element stores and load bookkeeping.
  logic [ELEM_BITS-1:0]        vec_mem [NVEC][MAX_DIM];
  logic signed [ELEM_BITS-1:0] rdat_q [NVEC];
  logic [CNT_W-1:0]            count_q, rd_ptr_q;
  logic                        ovf_q, v1_q, v2_q;
  logic                        wr_en, rd_en;

  // Dot product lanes.
  logic signed [PROD_W-1:0]    lane_prod_q [NDOT];
  logic signed [ACC_W-1:0]     acc_q [NDOT];
  logic signed [FIX_W-1:0]     dv_q [NDOT];
  logic signed [FIX_W-1:0]     dv_d [NDOT];

  // Scalar registers.
  logic signed [FIX_W-1:0]     dd_q, sq_q, num_q, r3_q;
  logic signed [FIX_W-1:0]     ma_q, mb_q, mc_q, md_q, s1_q, t_q, ur_q;
  logic [ROOT_W-1:0]           la_q, lb_q, s2_q, big_q, small_q;
  logic signed [63:0]          nacc_q, p_q, q_q, u_q;
  logic [RAD_W-1:0]            e_q;

  // Shared multiplier.
  logic signed [FIX_W-1:0]     mul_a, mul_b;
  logic signed [63:0]          prod_q, fq;

  // Long units.
  logic                        sqrt_start, div_start, sqrt_done, div_done;
  logic [RAD_W-1:0]            rad;
  logic [ROOT_W-1:0]           root;
  logic [DIV_N_W-1:0]          div_num, quo;
  logic [DIV_D_W-1:0]          div_den;
  logic [FIX_W-1:0]            mag;
  logic signed [FIX_W-1:0]     qsat, div_fix;
  logic signed [63:0]          s1e, s2e, sum12, dif12;

  // Result register.
  logic                        out_valid_q;
  logic [OUT_W-1:0]            out_data_q;
  logic [USER_W-1:0]           out_user_q;

  assign wr_en = cmd_i.load && (count_q < CNT_W'(MAX_DIM));
  assign rd_en = (cmd_i.step == CMD_DOT) && (rd_ptr_q != count_q);

  // Store writes on load and registered reads during the dot sweep.
  for (genvar j = 0; j < NVEC; j++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        vec_mem[j][count_q[ADDR_W-1:0]] <= in_data_i[j*ELEM_BITS +: ELEM_BITS];
      end
      if (rd_en) begin
        rdat_q[j] <= vec_mem[j][rd_ptr_q[ADDR_W-1:0]];
      end
    end
  end

  // Element count, overflow flag and sweep pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      rd_ptr_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      v1_q <= rd_en;
      v2_q <= v1_q;
      if (cmd_i.step == CMD_OUT) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (wr_en) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.load) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.step == CMD_DOT_INIT) begin
        rd_ptr_q <= '0;
      end else if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Lane products, accumulation and rounding to Q16.16.
  for (genvar k = 0; k < NDOT; k++) begin : g_lane
    logic signed [ACC_W-1:0] rsum;
    logic signed [63:0]      rsh;

    always_comb begin
      rsum   = acc_q[k] + ACC_W'(128);
      rsh    = rsum >>> 8;
      dv_d[k] = sat_fix(rsh);
    end

    always_ff @(posedge clk_i) begin
      lane_prod_q[k] <= rdat_q[DOT_L[k]] * rdat_q[DOT_R[k]];
      if (cmd_i.step == CMD_DOT_INIT) begin
        acc_q[k] <= '0;
      end else if (v2_q) begin
        acc_q[k] <= acc_q[k] + ACC_W'(lane_prod_q[k]);
      end
      if (cmd_i.step == CMD_ROUND) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      CMD_MUL_A12SQ:  begin mul_a = dv_q[D_A12]; mul_b = dv_q[D_A12]; end
      CMD_MUL_DDA:    begin mul_a = dd_q;        mul_b = dv_q[D_A11]; end
      CMD_MUL_B12SQ:  begin mul_a = dv_q[D_B12]; mul_b = dv_q[D_B12]; end
      CMD_MUL_DDB:    begin mul_a = dd_q;        mul_b = dv_q[D_B11]; end
      CMD_MUL_B12X11: begin mul_a = dv_q[D_B12]; mul_b = dv_q[D_X11]; end
      CMD_MUL_A12X11: begin mul_a = dv_q[D_A12]; mul_b = dv_q[D_X11]; end
      CMD_MUL_B12X21: begin mul_a = dv_q[D_B12]; mul_b = dv_q[D_X21]; end
      CMD_MUL_A12X12: begin mul_a = dv_q[D_A12]; mul_b = dv_q[D_X12]; end
      CMD_MUL_A12B12: begin mul_a = dv_q[D_A12]; mul_b = dv_q[D_B12]; end
      CMD_MUL_R3X11:  begin mul_a = r3_q;        mul_b = dv_q[D_X11]; end
      CMD_MUL_MAMA:   begin mul_a = ma_q;        mul_b = ma_q;        end
      CMD_MUL_MBMB:   begin mul_a = mb_q;        mul_b = mb_q;        end
      CMD_MUL_MCMC:   begin mul_a = mc_q;        mul_b = mc_q;        end
      CMD_MUL_MDMD:   begin mul_a = md_q;        mul_b = md_q;        end
      CMD_MUL_MAMC:   begin mul_a = ma_q;        mul_b = mc_q;        end
      CMD_MUL_MBMD:   begin mul_a = mb_q;        mul_b = md_q;        end
      CMD_MUL_TT:     begin mul_a = t_q;         mul_b = t_q;         end
      CMD_MUL_UU:     begin mul_a = ur_q;        mul_b = ur_q;        end
      default:        begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Product of the previous step, rounded to Q16.16.
  assign fq = 64'(sat_fix(rnd16(prod_q)));

  // Operands of the long units.
  assign s1e   = 64'(s1_q);
  assign s2e   = signed'({32'd0, s2_q});
  assign sum12 = s1e + s2e;
  assign dif12 = s1e - s2e;

  always_comb begin
    rad = '0;
    case (cmd_i.step)
      CMD_SQRT_LA, CMD_SQRT_LB: rad = (sq_q > 0) ? {16'd0, sq_q, 16'd0} : '0;
      CMD_SQRT_S2:              rad = e_q;
      CMD_SQRT_BIG:             rad = sum12 << 15;
      CMD_SQRT_SMALL:           rad = (s1e > s2e) ? (dif12 << 15) : '0;
      default:                  rad = '0;
    endcase
  end

  // Quotient in Q.16 of the magnitude, rounded to nearest.
  always_comb begin
    div_den = ((cmd_i.step == CMD_DIV_MC) || (cmd_i.step == CMD_DIV_MD1)) ? la_q : lb_q;
    mag     = num_q[FIX_W-1] ? FIX_W'(-num_q) : FIX_W'(num_q);
    div_num = (DIV_N_W'(mag) << 16) + DIV_N_W'(div_den >> 1);
    qsat    = (quo > DIV_N_W'(FIX_MAX)) ? FIX_MAX : quo[FIX_W-1:0];
    div_fix = num_q[FIX_W-1] ? -qsat : qsat;
  end

  assign sqrt_start = cmd_i.start && ((cmd_i.step == CMD_SQRT_LA) ||
                      (cmd_i.step == CMD_SQRT_LB) || (cmd_i.step == CMD_SQRT_S2) ||
                      (cmd_i.step == CMD_SQRT_BIG) || (cmd_i.step == CMD_SQRT_SMALL));
  assign div_start  = cmd_i.start && ((cmd_i.step == CMD_DIV_MB) ||
                      (cmd_i.step == CMD_DIV_MC) || (cmd_i.step == CMD_DIV_MD1) ||
                      (cmd_i.step == CMD_DIV_MD2));

  tppa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  tppa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Scalar steps and write back of the long units.
  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      CMD_DD_A, CMD_DD_B: dd_q <= fq[FIX_W-1:0];
      CMD_SQ_A: sq_q <= sat_fix(64'(dv_q[D_A22]) - (64'(dd_q) <<< 1) + fq);
      CMD_SQ_B: sq_q <= sat_fix(64'(dv_q[D_B22]) - (64'(dd_q) <<< 1) + fq);
      CMD_NB:   num_q <= sat_fix(64'(dv_q[D_X12]) - fq);
      CMD_NC:   num_q <= sat_fix(64'(dv_q[D_X21]) - fq);
      CMD_R1:   nacc_q <= 64'(dv_q[D_X22]) - fq;
      CMD_R2:   nacc_q <= nacc_q - fq;
      CMD_R3:   r3_q <= fq[FIX_W-1:0];
      CMD_R4:   num_q <= sat_fix(nacc_q + fq);
      CMD_MA:   ma_q <= sat_mat(64'(dv_q[D_X11]));
      CMD_P1:   p_q <= prod_q;
      CMD_P2:   p_q <= p_q + prod_q;
      CMD_Q1:   q_q <= prod_q;
      CMD_Q2:   q_q <= q_q + prod_q;
      CMD_U1:   u_q <= prod_q;
      CMD_U2:   u_q <= u_q + prod_q;
      CMD_RND: begin
        // Matrix entries stay below 64, so these sums fit in Q16.16.
        s1_q <= FIX_W'(rnd16(p_q + q_q));
        t_q  <= FIX_W'(rnd16(p_q - q_q));
        ur_q <= FIX_W'(rnd16(u_q));
      end
      CMD_TT:   e_q <= prod_q;
      CMD_UU:   e_q <= e_q + (prod_q << 2);
      CMD_SQRT_LA:    if (sqrt_done) la_q <= root;
      CMD_SQRT_LB:    if (sqrt_done) lb_q <= root;
      CMD_SQRT_S2:    if (sqrt_done) s2_q <= root;
      CMD_SQRT_BIG:   if (sqrt_done) big_q <= root;
      CMD_SQRT_SMALL: if (sqrt_done) small_q <= root;
      CMD_DIV_MB: if (div_done) mb_q <= (lb_q != '0) ? sat_mat(64'(div_fix)) : '0;
      CMD_DIV_MC: if (div_done) mc_q <= (la_q != '0) ? sat_mat(64'(div_fix)) : '0;
      CMD_DIV_MD1: if (div_done) num_q <= div_fix;
      CMD_DIV_MD2: begin
        if (div_done) begin
          md_q <= ((la_q != '0) && (lb_q != '0)) ? sat_mat(64'(div_fix)) : '0;
        end
      end
      default: ;
    endcase
  end

  // Result register; a new result is loaded only once the last one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step == CMD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == CMD_OUT) begin
      out_data_q <= {small_q, big_q};
      out_user_q <= {ovf_q, (la_q == '0) || (lb_q == '0)};
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;
  assign out_user_o         = out_user_q;
  assign status_o.dot_done  = (rd_ptr_q == count_q) && !v1_q && !v2_q;
  assign status_o.unit_done = sqrt_done || div_done;
  assign status_o.out_full  = out_valid_q;

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == CMD_OUT) |-> !out_valid_q)
    else $error("result loaded while previous result pending");

  // The element count never passes the store depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DIM))
    else $error("element count beyond store depth");

  // The divider and the square root unit never finish together.
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_done && div_done))
    else $error("both long units completed at once");

  // Lane products only follow a store read.
  a_lane_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("dot lane valid without read data");

endmodule

`default_nettype wire

// ----- src/tppa_ctrl.sv -----
// ----------------------------------------------------------------------------
// tppa_ctrl: controller of the principal angle engine
// Takes elements, runs the dot product sweep, then steps through the scalar
// program and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  tppa_pkg::status_t  status_i,
  output tppa_pkg::cmd_t     cmd_o
);
  import tppa_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_INIT = 6'b000010,
    ST_DOT  = 6'b000100,
    ST_RUN  = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  localparam logic [PC_W-1:0] LAST_PC = PC_W'(PROG_LEN - 1);

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  cmd_e            prog_step;

  assign prog_step = cmd_e'(pc_q);

  // Next state and command.
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    in_ready_o  = 1'b0;
    cmd_o.step  = CMD_NOP;
    cmd_o.start = 1'b0;
    cmd_o.load  = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.step = CMD_DOT_INIT;
        state_d    = ST_DOT;
      end
      ST_DOT: begin
        cmd_o.step = CMD_DOT;
        if (status_i.dot_done) begin
          pc_d    = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step  = prog_step;
        cmd_o.start = 1'b1;
        if (is_long(prog_step)) begin
          state_d = ST_WAIT;
        end else if (pc_q == LAST_PC) begin
          state_d = ST_FIN;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ST_WAIT: begin
        cmd_o.step = prog_step;
        if (status_i.unit_done) begin
          if (pc_q == LAST_PC) begin
            state_d = ST_FIN;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_FIN: begin
        if (!status_i.out_full) begin
          cmd_o.step = CMD_OUT;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // Waiting is only done on a step that uses a long unit.
  a_wait_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> is_long(cmd_o.step))
    else $error("waiting on a single-cycle step");

  // A long unit completes only while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.unit_done |-> (state_q == ST_WAIT))
    else $error("unit completion outside wait");

  // Loading resumes only after a result was handed over.
  a_ready_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(cmd_o.step == CMD_OUT))
    else $error("input reopened without a result");

endmodule

`default_nettype wire

// ----- src/two_plane_principal_angles_core.sv -----
// ----------------------------------------------------------------------------
// two_plane_principal_angles_core: principal angles between two planes
// Loads four vectors element by element, then gives the two singular values
// of the cross matrix of the orthonormalized planes in Q16.16.
// ----------------------------------------------------------------------------
// Load: one item per cycle into the element stores.
// After the last item, the dot product sweep reads every stored element, then the
// scalar steps run, with five square roots and four divisions on the shared
// units; the result then sits in a register.
// Items are taken again as soon as the result is in the output register.
// Reset clears the element count, the overflow flag and all control state.
`default_nettype none

module two_plane_principal_angles_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // first_a_elem, second_a_elem, first_b_elem, second_b_elem
  input  logic [tppa_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // sigma_large, sigma_small
  output logic [tppa_pkg::OUT_W-1:0]  m_axis_tdata_o,
  // degenerate, overflowed
  output logic [tppa_pkg::USER_W-1:0] m_axis_tuser_o
);
  import tppa_pkg::*;

  cmd_t    cmd;
  status_t status;

  tppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tppa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for two_plane_principal_angles_core
// Streams element runs of four vectors into the block and checks every
// result item against a bit-exact fixed-point predictor. Directed runs
// cover extreme values, degenerate planes and identical planes, one run
// overflows the element store, and random runs follow. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int  RAND_ITEMS = 2000;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  STORE_DEPTH = tppa_pkg::MAX_DIM;

  typedef struct {
    logic [31:0] sigma_large;
    logic [31:0] sigma_small;
    logic        degenerate;
    logic        overflowed;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [tppa_pkg::IN_W-1:0] s_data = '0;
  logic s_last = 1'b0;
  logic m_ready = 1'b0;
  logic s_ready;
  logic m_valid;
  logic [tppa_pkg::OUT_W-1:0] m_data;
  logic [tppa_pkg::USER_W-1:0] m_user;

  two_plane_principal_angles_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the four element stores, the count and the overflow flag.
  longint vec_a1 [STORE_DEPTH];
  longint vec_a2 [STORE_DEPTH];
  longint vec_b1 [STORE_DEPTH];
  longint vec_b2 [STORE_DEPTH];
  int     elem_cnt = 0;
  bit     elem_ovf = 1'b0;

  angles_t pending_angles[$];
  int      errors = 0;
  int      sent_items = 0;
  int      cycles = 0;
  int      burst_left = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the block.
  // ---------------------------------------------------------------------------
  function automatic longint lim(longint v, longint l);
    return (v > l) ? l : ((v < -l) ? -l : v);
  endfunction

  // Round to nearest with ties upward while dropping s fraction bits.
  function automatic longint round_drop(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return lim(round_drop(x * y, 16), 64'sd2147483647);
  endfunction

  // Q16 quotient, rounded half away from zero; den is positive.
  function automatic longint qdiv(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = lim((m * 65536 + den / 2) / den, 64'sd2147483647);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint dot_q16(ref longint x [STORE_DEPTH], ref longint y [STORE_DEPTH],
                                     input int n);
    longint acc;
    acc = 0;
    for (int i = 0; i < n; i++) acc += x[i] * y[i];
    return lim(round_drop(acc, 8), 64'sd2147483647);
  endfunction

  // Length of the part of v2 orthogonal to v1; zero for a degenerate plane.
  function automatic longint perp_length(longint n11, longint n22, longint d);
    longint dd;
    longint sq;
    dd = qmul(d, d);
    sq = lim(n22 - 2 * dd + qmul(dd, n11), 64'sd2147483647);
    if (sq <= 0) return 0;
    return longint'(int_sqrt(longint'(sq) << 16));
  endfunction

  // Singular values of the cross matrix of the loaded planes.
  function automatic angles_t expected_angles();
    angles_t r;
    longint a11, a22, a12, b11, b22, b12, x11, x12, x21, x22;
    longint la, lb, ma, mb, mc, md, p, q, s1, t, u, s2;
    longint mlim;
    longint unsigned big, sml;
    mlim = (64'sd1 <<< 22) - 1;
    a11 = dot_q16(vec_a1, vec_a1, elem_cnt);
    a22 = dot_q16(vec_a2, vec_a2, elem_cnt);
    a12 = dot_q16(vec_a1, vec_a2, elem_cnt);
    b11 = dot_q16(vec_b1, vec_b1, elem_cnt);
    b22 = dot_q16(vec_b2, vec_b2, elem_cnt);
    b12 = dot_q16(vec_b1, vec_b2, elem_cnt);
    x11 = dot_q16(vec_a1, vec_b1, elem_cnt);
    x12 = dot_q16(vec_a1, vec_b2, elem_cnt);
    x21 = dot_q16(vec_a2, vec_b1, elem_cnt);
    x22 = dot_q16(vec_a2, vec_b2, elem_cnt);
    la = perp_length(a11, a22, a12);
    lb = perp_length(b11, b22, b12);
    ma = lim(x11, mlim);
    mb = (lb != 0) ?
      lim(qdiv(lim(x12 - qmul(b12, x11), 64'sd2147483647), lb), mlim) : 0;
    mc = (la != 0) ?
      lim(qdiv(lim(x21 - qmul(a12, x11), 64'sd2147483647), la), mlim) : 0;
    md = (la != 0 && lb != 0) ?
      lim(qdiv(qdiv(lim(x22 - qmul(b12, x21) - qmul(a12, x12)
                        + qmul(qmul(a12, b12), x11), 64'sd2147483647), la), lb), mlim)
      : 0;
    p  = ma * ma + mb * mb;
    q  = mc * mc + md * md;
    s1 = round_drop(p + q, 16);
    t  = round_drop(p - q, 16);
    u  = round_drop(ma * mc + mb * md, 16);
    s2 = longint'(int_sqrt(longint'(t * t) + 4 * longint'(u * u)));
    big = int_sqrt(longint'(s1 + s2) << 15);
    sml = (s1 <= s2) ? 0 : int_sqrt(longint'(s1 - s2) << 15);
    r.sigma_large = big[31:0];
    r.sigma_small = sml[31:0];
    r.degenerate  = (la == 0 || lb == 0);
    r.overflowed  = elem_ovf;
    return r;
  endfunction

  // Update the predictor with one accepted element.
  task automatic take_element(logic [15:0] a1, logic [15:0] a2, logic [15:0] b1,
                              logic [15:0] b2, logic last);
    if (elem_cnt < STORE_DEPTH) begin
      vec_a1[elem_cnt] = longint'($signed(a1));
      vec_a2[elem_cnt] = longint'($signed(a2));
      vec_b1[elem_cnt] = longint'($signed(b1));
      vec_b2[elem_cnt] = longint'($signed(b2));
      elem_cnt++;
    end else begin
      elem_ovf = 1'b1;
    end
    if (last) begin
      pending_angles.push_back(expected_angles());
      elem_cnt = 0;
      elem_ovf = 1'b0;
    end
  endtask

  // Send one item; returns at the edge that accepted it, or after a gap.
  // Ready only changes at rising edges, so its value at the falling edge is
  // the one seen by the next rising edge.
  task automatic send_element(logic [15:0] a1, logic [15:0] a2, logic [15:0] b1,
                              logic [15:0] b2, logic last);
    int gap;
    bit rdy;
    s_valid <= 1'b1;
    s_data  <= {b2, b1, a2, a1};
    s_last  <= last;
    do begin
      @(negedge clk_i);
      rdy = s_ready;
      @(posedge clk_i);
    end while (!rdy);
    take_element(a1, a2, b1, b2, last);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Result checker. Outputs and ready only change at rising edges, so the
  // handshake seen at the falling edge is the one taken at the next edge.
  always @(negedge clk_i) begin
    angles_t e;
    if (m_valid && m_ready) begin
      if (pending_angles.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        e = pending_angles.pop_front();
        if (m_data[31:0] !== e.sigma_large)
          report($sformatf("sigma_large %0d, expected %0d", m_data[31:0], e.sigma_large));
        if (m_data[63:32] !== e.sigma_small)
          report($sformatf("sigma_small %0d, expected %0d", m_data[63:32], e.sigma_small));
        if (m_user[0] !== e.degenerate)
          report($sformatf("degenerate %0b, expected %0b", m_user[0], e.degenerate));
        if (m_user[1] !== e.overflowed)
          report($sformatf("overflowed %0b, expected %0b", m_user[1], e.overflowed));
      end
    end
  end

  // Cycle limit and receiver stall pattern.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_extremes();
    send_element(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_element(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b1);
    send_element(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_element(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
  endtask

  // Identical orthonormal planes, then orthogonal planes.
  task automatic test_unit_planes();
    send_element(16'd4096, 16'd0, 16'd4096, 16'd0, 1'b0);
    send_element(16'd0, 16'd4096, 16'd0, 16'd4096, 1'b0);
    send_element(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_element(16'd4096, 16'd0, 16'd0, 16'd0, 1'b0);
    send_element(16'd0, 16'd4096, 16'd0, 16'd0, 1'b0);
    send_element(16'd0, 16'd0, 16'd4096, 16'd0, 1'b0);
    send_element(16'd0, 16'd0, 16'd0, 16'd4096, 1'b1);
  endtask

  // A second vector parallel to the first, all-zero vectors, then non-orthogonal planes.
  task automatic test_degenerate();
    send_element(16'd2896, 16'd2896, 16'd4096, 16'd0, 1'b0);
    send_element(16'd2896, 16'd2896, 16'd0, 16'd4096, 1'b1);
    send_element(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_element(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_element(16'd4096, 16'd1000, 16'd4096, 16'hF000, 1'b0);
    send_element(16'd0, 16'd1000, 16'd0, 16'hF000, 1'b1);
  endtask

  // More elements than the store holds; the last one falls past capacity.
  task automatic test_overflow();
    for (int i = 0; i <= STORE_DEPTH; i++)
      send_element(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                   16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                   i == STORE_DEPTH);
  endtask

  // Random runs: mostly short, with random magnitude and sometimes equal planes.
  task automatic test_random_runs();
    int n;
    int sh;
    int pick;
    bit same;
    logic [15:0] a1, a2, b1, b2;
    while (sent_items < RAND_ITEMS + 64) begin
      pick = $urandom_range(0, 99);
      n = (pick < 80) ? $urandom_range(1, 8) :
          (pick < 96) ? $urandom_range(9, 64) : $urandom_range(65, 300);
      sh = $urandom_range(0, 15);
      same = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n; i++) begin
        a1 = 16'($signed($urandom) >>> (16 + sh));
        a2 = 16'($signed($urandom) >>> (16 + $urandom_range(0, 15)));
        b1 = same ? a1 : 16'($signed($urandom) >>> (16 + sh));
        b2 = same ? a2 : 16'($signed($urandom) >>> (16 + $urandom_range(0, 15)));
        send_element(a1, a2, b1, b2, i == n - 1);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_unit_planes();
    test_degenerate();
    test_overflow();
    test_random_runs();
    s_valid <= 1'b0;
    s_last  <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
